[rtl/csb_pkg.sv]
// Shared types and constants for the capsule brush sampler.
// Used by the channel interfaces and the top-level pipeline; no dependencies.
package csb_pkg;

    // Input coordinate format and register field widths.
    localparam int COORD_W = 21;
    localparam int FRAC_W  = 8;
    localparam int MAT_W   = 16;
    localparam int SIZE_W  = 20;
    localparam int LVL_W   = 16;
    localparam int CFG_W   = 63;
    localparam int ADDR_W  = 3;

    // Internal datapath widths.
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + MAT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int LOC_W  = 26;
    localparam int SQ_W   = 2 * LOC_W;
    localparam int LIM_W  = SIZE_W + 2;
    localparam int Q_W    = 16;
    localparam int T_W    = Q_W + 1;
    localparam int VAL_W  = LVL_W + 1;

    // Bounds padding: 2.0 in the coordinate format.
    localparam int PAD = 2 << FRAC_W;

    // Pipeline stage map.
    localparam int ST_DIFF = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_ROT  = 2;
    localparam int ST_MAG  = 3;
    localparam int ST_SQR  = 4;
    localparam int ST_SUM  = 5;
    localparam int SQRT_N  = LOC_W;
    localparam int ST_RT0  = 6;
    localparam int ST_SD   = ST_RT0 + SQRT_N;
    localparam int ST_DV0  = ST_SD + 1;
    localparam int ST_T2   = ST_DV0 + Q_W;
    localparam int ST_S    = ST_T2 + 1;
    localparam int ST_LRP  = ST_S + 1;
    localparam int ST_VAL  = ST_LRP + 1;
    localparam int ST_SCL  = ST_VAL + 1;
    localparam int ST_OUT  = ST_SCL + 1;
    localparam int NST     = ST_OUT + 1;

    // Configuration register indexes.
    typedef enum logic [ADDR_W-1:0] {
        CFG_CENTER   = 3'd0,
        CFG_ROW_X    = 3'd1,
        CFG_ROW_Y    = 3'd2,
        CFG_ROW_Z    = 3'd3,
        CFG_SIZES    = 3'd4,
        CFG_STRENGTH = 3'd5,
        CFG_DIG      = 3'd6,
        CFG_LEVELS   = 3'd7
    } t_cfg_idx;

    // Bounds flags that travel with an item.
    typedef struct packed {
        logic bnd;
        logic intr;
    } t_flags;

    // One square-root iteration stage: remainder and partial root.
    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } t_sq_item;

    // One division stage: partial remainder, quotient and edge cases.
    typedef struct packed {
        logic [SIZE_W:0] rem;
        logic [Q_W-1:0]  q;
        logic            zero;
        logic            full;
    } t_dv_item;

endpackage

[rtl/csb_if.sv]
// Valid/ready channel interfaces for the capsule brush sampler.
// Depends on csb_pkg for field widths.
interface csb_in_if import csb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface csb_out_if import csb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [LVL_W-1:0] field_value;
    logic                    in_bounds;
    logic                    in_interior;
    modport source (output valid, field_value, in_bounds, in_interior, input ready);
    modport sink (input valid, field_value, in_bounds, in_interior, output ready);
endinterface

interface csb_cfg_if import csb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;
    logic [CFG_W-1:0]  data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

[rtl/capsule_sdf_brush_sample.sv]
// Capsule brush sampler: fully pipelined signed-distance datapath.
// Depends on csb_pkg and the channel interfaces in csb_if.sv.

// The block takes one position item per clock while the output is not stalled
// and returns one result item per position, in order. The pipeline holds the
// 26-stage square-root chain and the 16-stage blend-factor divider, each of
// which resolves one bit per stage. Every stage holds its own valid bit and
// empty stages fill while the output waits, so a stall loses nothing.
// Configuration writes are taken at once and must only be made while no item
// is in flight.
module capsule_sdf_brush_sample
    import csb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    csb_in_if.sink     i_in,
    csb_cfg_if.sink    i_cfg,
    csb_out_if.source  o_out
);

    // Configuration registers.
    logic [3*COORD_W-1:0] r_center;
    logic [3*MAT_W-1:0]   r_row [3];
    logic [3*SIZE_W-1:0]  r_sizes;
    logic signed [15:0]   r_strength;
    logic                 r_dig;
    logic [2*LVL_W-1:0]   r_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= '0;
            r_row[0]   <= 48'd16384;
            r_row[1]   <= 48'd16384 << 16;
            r_row[2]   <= 48'd16384 << 32;
            r_sizes    <= '0;
            r_strength <= 16'sd256;
            r_dig      <= 1'b1;
            r_levels   <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.addr))
                CFG_CENTER:   r_center   <= i_cfg.data[3*COORD_W-1:0];
                CFG_ROW_X:    r_row[0]   <= i_cfg.data[3*MAT_W-1:0];
                CFG_ROW_Y:    r_row[1]   <= i_cfg.data[3*MAT_W-1:0];
                CFG_ROW_Z:    r_row[2]   <= i_cfg.data[3*MAT_W-1:0];
                CFG_SIZES:    r_sizes    <= i_cfg.data[3*SIZE_W-1:0];
                CFG_STRENGTH: r_strength <= $signed(i_cfg.data[15:0]);
                CFG_DIG:      r_dig      <= i_cfg.data[0];
                CFG_LEVELS:   r_levels   <= i_cfg.data[2*LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Decoded shape and level fields.
    logic [SIZE_W-1:0]       w_half, w_rad, w_fall;
    logic signed [LVL_W-1:0] w_inner, w_outer;
    assign w_half  = r_sizes[SIZE_W-1:0];
    assign w_rad   = r_sizes[2*SIZE_W-1:SIZE_W];
    assign w_fall  = r_sizes[3*SIZE_W-1:2*SIZE_W];
    assign w_inner = r_dig ? $signed(r_levels[LVL_W-1:0]) : $signed(r_levels[2*LVL_W-1:LVL_W]);
    assign w_outer = r_dig ? $signed(r_levels[2*LVL_W-1:LVL_W]) : $signed(r_levels[LVL_W-1:0]);

    // Stage valid bits and the stall chain: a stage may load when it is empty
    // or when its item moves on in the same cycle.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    // Stage 0: subtract the brush center.
    logic signed [DIFF_W-1:0] r_d [3];
    logic signed [COORD_W-1:0] w_pos [3];
    assign w_pos[0] = i_in.pos_x;
    assign w_pos[1] = i_in.pos_y;
    assign w_pos[2] = i_in.pos_z;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIFF]) begin
            for (int j = 0; j < 3; j++) begin
                r_d[j] <= DIFF_W'(w_pos[j]) - DIFF_W'($signed(r_center[j*COORD_W +: COORD_W]));
            end
        end
    end

    // Stage 1: the nine matrix products.
    logic signed [PROD_W-1:0] r_prod [3][3];
    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= $signed(r_row[i][j*MAT_W +: MAT_W]) * r_d[j];
                end
            end
        end
    end

    // Stage 2: row sums, rounded half up to the coordinate format.
    logic signed [LOC_W-1:0] r_loc [3];
    logic signed [ACC_W-1:0] n_acc [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = ACC_W'(r_prod[i][0]) + ACC_W'(r_prod[i][1]) + ACC_W'(r_prod[i][2])
                     + ACC_W'(8192);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en[ST_ROT]) begin
            for (int i = 0; i < 3; i++) begin
                r_loc[i] <= n_acc[i][ACC_W-1-(ACC_W-14-LOC_W) -: LOC_W];
            end
        end
    end

    // Stage 3: magnitudes and the distance beyond the segment along z.
    logic [LOC_W-1:0]        r_hx, r_hy, r_dz, r_az;
    logic signed [LOC_W-1:0] n_halfs, n_dz;
    always_comb begin
        n_halfs = $signed(LOC_W'(w_half));
        if (r_loc[2] > n_halfs) begin
            n_dz = r_loc[2] - n_halfs;
        end else if (r_loc[2] < -n_halfs) begin
            n_dz = -n_halfs - r_loc[2];
        end else begin
            n_dz = '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en[ST_MAG]) begin
            r_hx <= r_loc[0][LOC_W-1] ? LOC_W'(-r_loc[0]) : LOC_W'(r_loc[0]);
            r_hy <= r_loc[1][LOC_W-1] ? LOC_W'(-r_loc[1]) : LOC_W'(r_loc[1]);
            r_az <= r_loc[2][LOC_W-1] ? LOC_W'(-r_loc[2]) : LOC_W'(r_loc[2]);
            r_dz <= LOC_W'(n_dz);
        end
    end

    // Stage 4: squares, plus the squared radial limits.
    logic [SQ_W-1:0]    r_hx2, r_hy2, r_dz2;
    logic [LOC_W-1:0]   r_az4;
    logic [2*LIM_W-1:0] r_hlim2;
    logic [2*SIZE_W-1:0] r_rad2;
    logic [LIM_W-1:0]   n_hlim;
    assign n_hlim = LIM_W'(w_rad) + LIM_W'(w_fall) + LIM_W'(PAD);
    always_ff @(posedge i_clk) begin
        if (w_en[ST_SQR]) begin
            r_hx2   <= r_hx * r_hx;
            r_hy2   <= r_hy * r_hy;
            r_dz2   <= r_dz * r_dz;
            r_az4   <= r_az;
            r_hlim2 <= n_hlim * n_hlim;
            r_rad2  <= w_rad * w_rad;
        end
    end

    // Stage 5: squared distance and the two bounds tests.
    t_flags          r_fl [NST];
    logic [SQ_W-1:0] r_sum;
    logic [SQ_W-1:0] n_hd2;
    logic [LIM_W-1:0] n_vlim;
    logic [SIZE_W:0] n_hr;
    assign n_hd2  = r_hx2 + r_hy2;
    assign n_vlim = LIM_W'(w_half) + LIM_W'(w_rad) + LIM_W'(w_fall) + LIM_W'(PAD);
    assign n_hr   = (SIZE_W+1)'(w_half) + (SIZE_W+1)'(w_rad);
    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_sum           <= n_hd2 + r_dz2;
            r_fl[ST_SUM].bnd  <= (r_az4 <= LOC_W'(n_vlim)) && (n_hd2 <= SQ_W'(r_hlim2));
            r_fl[ST_SUM].intr <= (r_az4 <= LOC_W'(n_hr)) && (n_hd2 <= SQ_W'(r_rad2));
        end
        for (int k = ST_SUM + 1; k < NST; k++) begin
            if (w_en[k]) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    // Square root: one result bit per stage, digit by digit.
    t_sq_item r_sq [SQRT_N];
    t_sq_item n_sq [SQRT_N];
    always_comb begin
        t_sq_item cur;
        logic [SQ_W-1:0] bitv;
        for (int k = 0; k < SQRT_N; k++) begin
            if (k == 0) begin
                cur.v   = r_sum;
                cur.res = '0;
            end else begin
                cur = r_sq[k-1];
            end
            bitv = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            if (cur.v >= cur.res + bitv) begin
                n_sq[k].v   = cur.v - (cur.res + bitv);
                n_sq[k].res = (cur.res >> 1) + bitv;
            end else begin
                n_sq[k].v   = cur.v;
                n_sq[k].res = cur.res >> 1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQRT_N; k++) begin
            if (w_en[ST_RT0 + k]) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    // Signed distance and the blend-factor edge cases.
    t_dv_item r_dv [Q_W + 1];
    logic signed [LOC_W+1:0] n_sd;
    assign n_sd = $signed({2'b0, r_sq[SQRT_N-1].res[LOC_W-1:0]}) - $signed((LOC_W+2)'(w_rad));
    always_ff @(posedge i_clk) begin
        if (w_en[ST_SD]) begin
            r_dv[0].zero <= (n_sd <= 0);
            r_dv[0].full <= (w_fall == '0) || (n_sd >= $signed((LOC_W+2)'(w_fall)));
            r_dv[0].rem  <= (SIZE_W+1)'(n_sd[SIZE_W-1:0]);
            r_dv[0].q    <= '0;
        end
    end

    // Restoring divider for sd / falloff, one quotient bit per stage.
    t_dv_item n_dv [Q_W];
    always_comb begin
        logic [SIZE_W:0] rem2;
        for (int k = 0; k < Q_W; k++) begin
            n_dv[k] = r_dv[k];
            rem2 = r_dv[k].rem << 1;
            if (rem2 >= (SIZE_W+1)'(w_fall)) begin
                n_dv[k].rem = rem2 - (SIZE_W+1)'(w_fall);
                n_dv[k].q   = {r_dv[k].q[Q_W-2:0], 1'b1};
            end else begin
                n_dv[k].rem = rem2;
                n_dv[k].q   = {r_dv[k].q[Q_W-2:0], 1'b0};
            end
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (w_en[ST_DV0 + k]) begin
                r_dv[k+1] <= n_dv[k];
            end
        end
    end

    // Smoothstep, first product: t squared. Inside the capsule the inner
    // level wins even when there is no falloff band.
    logic [T_W-1:0]   r_t, r_t2;
    logic [T_W-1:0]   n_t;
    logic [2*T_W-1:0] n_tt;
    always_comb begin
        if (r_dv[Q_W].zero) begin
            n_t = '0;
        end else if (r_dv[Q_W].full) begin
            n_t = T_W'(1) << Q_W;
        end else begin
            n_t = T_W'(r_dv[Q_W].q);
        end
        n_tt = n_t * n_t;
    end
    always_ff @(posedge i_clk) begin
        if (w_en[ST_T2]) begin
            r_t  <= n_t;
            r_t2 <= n_tt[Q_W +: T_W];
        end
    end

    // Smoothstep, second product: t^2 * (3 - 2t).
    logic [T_W-1:0]     r_s;
    logic [T_W:0]       n_f;
    logic [2*T_W:0]     n_sp;
    assign n_f  = (T_W+1)'(3 << Q_W) - (T_W+1)'({r_t, 1'b0});
    assign n_sp = r_t2 * n_f;
    always_ff @(posedge i_clk) begin
        if (w_en[ST_S]) begin
            r_s <= n_sp[Q_W +: T_W];
        end
    end

    // Blend: (outer - inner) * s.
    logic signed [VAL_W+T_W:0] r_lp;
    logic signed [VAL_W-1:0]   n_diff;
    assign n_diff = VAL_W'(w_outer) - VAL_W'(w_inner);
    always_ff @(posedge i_clk) begin
        if (w_en[ST_LRP]) begin
            r_lp <= n_diff * $signed({1'b0, r_s});
        end
    end

    // Blend: add the inner level.
    logic signed [VAL_W-1:0] r_val;
    always_ff @(posedge i_clk) begin
        if (w_en[ST_VAL]) begin
            r_val <= VAL_W'(w_inner) + VAL_W'(r_lp[VAL_W+T_W:Q_W]);
        end
    end

    // Strength scale.
    logic signed [VAL_W+15:0] r_m;
    always_ff @(posedge i_clk) begin
        if (w_en[ST_SCL]) begin
            r_m <= r_val * r_strength;
        end
    end

    // Round, saturate and hold the result.
    logic signed [LVL_W-1:0] r_fv;
    logic signed [VAL_W+16:0] n_rnd;
    logic signed [VAL_W+8:0]  n_sc;
    assign n_rnd = (VAL_W+17)'(r_m) + (VAL_W+17)'(128);
    assign n_sc  = n_rnd[VAL_W+16:8];
    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            if (n_sc > (VAL_W+9)'(32767)) begin
                r_fv <= 16'sh7FFF;
            end else if (n_sc < -(VAL_W+9)'(32768)) begin
                r_fv <= 16'sh8000;
            end else begin
                r_fv <= n_sc[LVL_W-1:0];
            end
        end
    end

    assign o_out.valid       = r_vld[ST_OUT];
    assign o_out.field_value = r_fv;
    assign o_out.in_bounds   = r_fl[ST_OUT].bnd;
    assign o_out.in_interior = r_fl[ST_OUT].intr;

    // The input stalls only when the first stage holds an item.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_vld[0])
        else $error("input stalled with an empty first stage");

    // The first stage keeps an item that it holds and cannot pass on.
    a_first_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !w_en[0] |=> r_vld[0])
        else $error("item dropped from first stage");

    // The interior cylinder lies inside the padded one.
    a_nested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.in_interior || o_out.in_bounds))
        else $error("interior flag set outside bounds");

endmodule
